[rtl/bit_vector_engine_unit_assert.svh]
// Assertion macros for the bit vector engine.
// Included by the top level; set NO_ASSERTIONS to compile them out.
`ifndef BIT_VECTOR_ENGINE_UNIT_ASSERT_SVH
`define BIT_VECTOR_ENGINE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BVE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bve check failed");
`define BVE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bve check failed");
`else
`define BVE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BVE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/bve_pkg.sv]
// Shared types and constants for the bit vector engine.
// No dependencies.
package bve_pkg;
   localparam int CAPACITY_WORDS_DEF = 16;
   localparam int WORD_BITS_DEF = 64;
   localparam int LEN_W = 11;
   localparam int KIND_W = 4;
   localparam int OPB_W = 7;
   localparam int OPW_W = 64;

   localparam logic [3:0] K_READ = 4'd0;
   localparam logic [3:0] K_WRITE = 4'd1;
   localparam logic [3:0] K_APPEND = 4'd2;
   localparam logic [3:0] K_SETALL = 4'd3;
   localparam logic [3:0] K_FLIP = 4'd4;
   localparam logic [3:0] K_CLEAR = 4'd5;
   localparam logic [3:0] K_OR = 4'd6;
   localparam logic [3:0] K_AND = 4'd7;
   localparam logic [3:0] K_XOR = 4'd8;
   localparam logic [3:0] K_SHL = 4'd9;
   localparam logic [3:0] K_SHR = 4'd10;
   localparam logic [3:0] K_NEW = 4'd11;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_OVER = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_SETUP, S_SWEEP, S_SCAN, S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture item, compute single-word op and new length
      logic sweep;   // write one word of the whole-vector op
      logic scan;    // fold one word into none/all flags
      logic clr_cnt; // restart word counter
      logic adv;     // advance word counter
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic whole;   // item needs a sweep over all words
      logic last;    // counter at last word
   } sts_type;
endpackage

[rtl/bve_ctrl.sv]
// Controller for the bit vector engine: sequences sweep and flag scan.
// Depends on bve_pkg.
module bve_ctrl import bve_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_SETUP;
         S_SETUP: state_in = sts.whole ? S_SWEEP : S_SCAN;
         S_SWEEP: if (sts.last) state_in = S_SCAN;
         S_SCAN: if (sts.last) state_in = S_DONE;
         S_DONE: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         S_SETUP: cmd.clr_cnt = 1'b1;
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            cmd.adv = 1'b1;
            cmd.clr_cnt = sts.last;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            cmd.adv = 1'b1;
         end
         S_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

[rtl/bve_dp.sv]
// Datapath for the bit vector engine: word store, length, shift and flags.
// Depends on bve_pkg.
module bve_dp import bve_pkg::*; #(
   parameter int CAPACITY_WORDS = CAPACITY_WORDS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [LEN_W-1:0]   req_position,
   input  logic               req_bit_value,
   input  logic [3:0]         req_word_index,
   input  logic [OPW_W-1:0]   req_operand_word,
   input  logic [OPB_W-1:0]   req_operand_bits,
   output logic               rsp_bit_out,
   output logic               rsp_none_set,
   output logic               rsp_all_set,
   output logic [LEN_W-1:0]   rsp_vector_length,
   output logic [1:0]         rsp_status
);
   localparam int CAP_BITS = CAPACITY_WORDS * WORD_BITS;
   localparam int IW = (CAPACITY_WORDS > 1) ? $clog2(CAPACITY_WORDS) : 1;
   localparam int BW = $clog2(WORD_BITS) > 0 ? $clog2(WORD_BITS) : 1;
   localparam int LW = $clog2(CAP_BITS + 1) + 1;
   localparam int SW = LW + 1;
   localparam int CW = IW + 1;
   localparam logic [LW-1:0] CAP_L = LW'(CAP_BITS);
   localparam logic [CW-1:0] LAST = CW'(CAPACITY_WORDS - 1);

   logic [WORD_BITS-1:0] store_ff [CAPACITY_WORDS];
   logic [WORD_BITS-1:0] store_in [CAPACITY_WORDS];
   logic [LW-1:0]        len_ff, len_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [KIND_W-1:0]    kind_ff;
   logic [LEN_W-1:0]     pos_ff;
   logic                 bit_ff, none_ff, all_ff;
   logic [1:0]           status_ff;
   logic                 bit_in;
   logic [1:0]           status_in;

   function automatic logic [WORD_BITS-1:0] low_mask(input logic [SW-1:0] k);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int j = 0; j < WORD_BITS; j++) m[j] = (SW'(j) < k);
      return m;
   endfunction

   function automatic logic [WORD_BITS-1:0] len_mask_of(input logic [LW-1:0] l,
                                                       input logic [CW-1:0] w);
      logic [SW-1:0] base;
      base = SW'(w) * SW'(WORD_BITS);
      if ({1'b0, l} <= base) return '0;
      return low_mask({1'b0, l} - base);
   endfunction

   // item decode
   logic [LW-1:0] pos_l;
   logic          pos_in_rng;
   logic [IW-1:0] pw;
   logic [BW-1:0] pb;
   logic [IW-1:0] lw_i;
   logic [BW-1:0] lb;
   logic          widx_ok;
   logic [IW-1:0] widx;
   logic [WORD_BITS-1:0] opm, opo;
   logic [LW:0]   shl_sum;

   assign pos_l = LW'(req_position);
   assign pos_in_rng = pos_l < len_ff;
   assign pw = IW'(pos_l / LW'(WORD_BITS));
   assign pb = BW'(pos_l % LW'(WORD_BITS));
   assign lw_i = IW'(len_ff / LW'(WORD_BITS));
   assign lb = BW'(len_ff % LW'(WORD_BITS));
   assign widx_ok = 32'(req_word_index) < 32'(CAPACITY_WORDS);
   assign widx = IW'(req_word_index);
   assign opm = low_mask(SW'(req_operand_bits)) & len_mask_of(len_ff, CW'(widx));
   assign opo = req_operand_word[WORD_BITS-1:0] & opm;
   assign shl_sum = {1'b0, len_ff} + (LW+1)'(req_position);

   // shift amount in whole words and the bit remainder; flag scan word
   logic [CW-1:0]  wi;
   logic [LEN_W-1:0] q;
   logic [BW-1:0]  r;
   logic [WORD_BITS-1:0] lm_new, lm_old;

   assign wi = cnt_ff;
   assign q = pos_ff / LEN_W'(WORD_BITS);
   assign r = BW'(pos_ff % LEN_W'(WORD_BITS));
   assign lm_new = len_mask_of(len_ff, wi);
   assign lm_old = store_ff[IW'(wi)];

   // shifts must not read words the sweep already overwrote: shl goes high to low,
   // shr low to high, so the sweep index order depends on kind
   logic [CW-1:0] sweep_idx;
   assign sweep_idx = (kind_ff == K_SHL) ? (LAST - cnt_ff) : cnt_ff;

   // shift source for the index actually swept
   logic [WORD_BITS-1:0] sh_word, sa, sb;
   logic [LW:0] su, sd;
   logic [2*WORD_BITS-1:0] sdbl;
   always_comb begin
      sa = '0;
      sb = '0;
      su = (LW+1)'(sweep_idx) - (LW+1)'(q);
      sd = (LW+1)'(sweep_idx) + (LW+1)'(q);
      if (kind_ff == K_SHL) begin
         if ((LW+1)'(sweep_idx) >= (LW+1)'(q)) sa = store_ff[IW'(su)];
         if ((LW+1)'(sweep_idx) >= (LW+1)'(q) + (LW+1)'(1))
            sb = store_ff[IW'(su - (LW+1)'(1))];
         sdbl = {sa, sb} << r;
         sh_word = sdbl[2*WORD_BITS-1:WORD_BITS];
      end else begin
         if (sd < (LW+1)'(CAPACITY_WORDS)) sa = store_ff[IW'(sd)];
         if (sd + (LW+1)'(1) < (LW+1)'(CAPACITY_WORDS))
            sb = store_ff[IW'(sd + (LW+1)'(1))];
         sdbl = {sb, sa} >> r;
         sh_word = sdbl[WORD_BITS-1:0];
      end
   end

   logic [WORD_BITS-1:0] sweep_val;
   logic [WORD_BITS-1:0] lm_sw;
   always_comb begin
      lm_sw = len_mask_of(len_ff, sweep_idx);
      sweep_val = store_ff[IW'(sweep_idx)];
      case (kind_ff)
         K_SETALL: sweep_val = lm_sw;
         K_FLIP: sweep_val = store_ff[IW'(sweep_idx)] ^ lm_sw;
         K_CLEAR, K_NEW: sweep_val = '0;
         K_SHL, K_SHR: sweep_val = sh_word & lm_sw;
         default: ;
      endcase
   end

   always_comb begin
      for (int k = 0; k < CAPACITY_WORDS; k++) store_in[k] = store_ff[k];
      len_in = len_ff;
      bit_in = bit_ff;
      status_in = status_ff;
      if (cmd.load) begin
         bit_in = 1'b0;
         status_in = ST_OK;
         case (req_kind)
            K_READ: begin
               if (!pos_in_rng) status_in = ST_RANGE;
               else bit_in = store_ff[pw][pb];
            end
            K_WRITE: begin
               if (!pos_in_rng) status_in = ST_RANGE;
               else store_in[pw][pb] = req_bit_value;
            end
            K_APPEND: begin
               if (len_ff >= CAP_L) status_in = ST_OVER;
               else begin
                  store_in[lw_i][lb] = store_ff[lw_i][lb] | req_bit_value;
                  len_in = len_ff + LW'(1);
               end
            end
            K_OR, K_AND, K_XOR: begin
               if (!widx_ok) status_in = ST_RANGE;
               else if (req_kind == K_OR) store_in[widx] = store_ff[widx] | opo;
               else if (req_kind == K_AND) store_in[widx] = store_ff[widx] & (~opm | opo);
               else store_in[widx] = store_ff[widx] ^ opo;
            end
            K_SHL: begin
               if (shl_sum > (LW+1)'(CAP_BITS)) begin
                  len_in = CAP_L;
                  status_in = ST_OVER;
               end else len_in = LW'(shl_sum);
            end
            K_SHR: begin
               if (pos_in_rng) len_in = len_ff - pos_l;
               else len_in = '0;
            end
            K_NEW: begin
               if (pos_l > CAP_L) begin
                  len_in = CAP_L;
                  status_in = ST_OVER;
               end else len_in = pos_l;
            end
            default: ;
         endcase
      end
      if (cmd.sweep) store_in[IW'(sweep_idx)] = sweep_val;
   end

   logic whole_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CAPACITY_WORDS; k++) store_ff[k] <= '0;
         len_ff <= '0;
         cnt_ff <= '0;
      end else begin
         for (int k = 0; k < CAPACITY_WORDS; k++) store_ff[k] <= store_in[k];
         len_ff <= len_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         pos_ff <= req_position;
         whole_ff <= (req_kind == K_SETALL) || (req_kind == K_FLIP) ||
                     (req_kind == K_CLEAR) || (req_kind == K_SHL) ||
                     (req_kind == K_SHR) || (req_kind == K_NEW);
      end
      bit_ff <= bit_in;
      status_ff <= status_in;
      if (cmd.clr_cnt && !cmd.adv) begin
         none_ff <= 1'b1;
         all_ff <= 1'b1;
      end else if (cmd.sweep && cmd.clr_cnt) begin
         none_ff <= 1'b1;
         all_ff <= 1'b1;
      end else if (cmd.scan) begin
         if (lm_old != '0) none_ff <= 1'b0;
         if (lm_old != lm_new) all_ff <= 1'b0;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clr_cnt) cnt_in = '0;
      else if (cmd.adv) cnt_in = cnt_ff + CW'(1);
   end

   assign sts.whole = whole_ff;
   assign sts.last = (cnt_ff == LAST);

   assign rsp_bit_out = bit_ff;
   assign rsp_none_set = none_ff || (len_ff == '0);
   assign rsp_all_set = all_ff || (len_ff == '0);
   assign rsp_vector_length = LEN_W'(len_ff);
   assign rsp_status = status_ff;
endmodule

[rtl/bit_vector_engine_unit.sv]
// Bit vector engine: a variable-length bit vector stored as words, with bit,
// word and whole-vector operations. Single-bit and single-word items go
// through a setup step and then the one-word-per-cycle flag scan before
// rsp_valid rises; whole-vector items (setall, flip, clear, shl, shr, new)
// add the one-word-per-cycle sweep between setup and scan. A stall on the
// result holds the engine until the result is taken. One item at a time; no
// new item is accepted before the result is taken, and req_stall is high
// from accept until the result is taken.
`include "bit_vector_engine_unit_assert.svh"
module bit_vector_engine_unit import bve_pkg::*; #(
   parameter int CAPACITY_WORDS = CAPACITY_WORDS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [LEN_W-1:0]  req_position,
   input  logic              req_bit_value,
   input  logic [3:0]        req_word_index,
   input  logic [OPW_W-1:0]  req_operand_word,
   input  logic [OPB_W-1:0]  req_operand_bits,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_bit_out,
   output logic              rsp_none_set,
   output logic              rsp_all_set,
   output logic [LEN_W-1:0]  rsp_vector_length,
   output logic [1:0]        rsp_status
);
   cmd_type cmd;
   sts_type sts;

   bve_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   bve_dp #(.CAPACITY_WORDS(CAPACITY_WORDS), .WORD_BITS(WORD_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_kind, .req_position, .req_bit_value, .req_word_index,
      .req_operand_word, .req_operand_bits,
      .rsp_bit_out, .rsp_none_set, .rsp_all_set, .rsp_vector_length, .rsp_status
   );

   `BVE_ASSERT_IMPL(a_one_side, clock, reset, rsp_valid, req_stall)
   `BVE_ASSERT_NEXT(a_load_busy, clock, reset, cmd.load, !rsp_valid && req_stall)
   `BVE_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)
endmodule
